/* hdl/wmsa_pkg.sv */
// shared constants and widths for the windowed mean slow alarm block
// no dependencies; imported by wmsa_div, windowed_mean_slow_alarm_top and tb_top
`default_nettype none

package wmsa_pkg;

  // window geometry
  localparam int WINDOW = 100;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // field widths
  localparam int GEN_W    = 32;
  localparam int DUR_W    = 24;
  localparam int GAME_W   = 32;
  localparam int TOTAL_W  = 32;
  localparam int REPORT_COUNT_W = 7;
  localparam int PERIOD_W = 16;

  // running sum holds WINDOW full-scale durations exactly
  localparam int SUM_W = DUR_W + CNT_W;

  // stream payload widths
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 216;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_LIMIT   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PUBLISH_PERIOD = 2'd1;

  localparam logic [DUR_W-1:0]    LIMIT_RESET  = 24'd10000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hdl/wmsa_div.sv */
// bit-serial restoring divider: window sum by sample count, one quotient bit a cycle
// depends on wmsa_pkg
`default_nettype none

module wmsa_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire wmsa_pkg::div_req_t req,
  output wmsa_pkg::div_rsp_t     rsp
);
  import wmsa_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   rem;
  logic [SUM_W-1:0]   quo;
  logic [CNT_W-1:0]   dvsr;
  logic               done;
  logic [CNT_W:0]     trial;
  logic               fits;

  // trial subtract of the next dividend bit
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  // control: busy flag, step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? CNT_W'(trial - {1'b0, dvsr}) : CNT_W'(trial);
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

/* hdl/windowed_mean_slow_alarm_top.sv */
// top level of the windowed mean slow alarm: sample ring memory, running sum,
// alarm state, report register; depends on wmsa_pkg and wmsa_div
//
//   s_axis carries one turn record per transaction (tdata, low bit first):
//   gen_tag, duration_us, turn_number, minutes_value. m_axis carries at most
//   one report per record. Configuration is a plain write port (cfg_we,
//   cfg_addr, cfg_data): index 0 sample_limit_us, index 1 publish_period. The user
//   must see that they are written only while the block is idle; the block does not
//   enforce it. A record with a nonzero generation passes, from acceptance to the
//   report being loaded, through ST_READ (sum update), ST_CMP (compare, which
//   starts the divider), ST_DIV (bit-serial divide of the 31-bit sum by the sample
//   count, until the divider signals done) and ST_FIN (load the report register).
//   The block takes no new record until it has returned to ST_IDLE, so records are
//   not overlapped. A generation-zero record finishes in its accept cycle, no report.
//   The report register decouples the sides: the next record is accepted while
//   a report waits; if the receiver still stalls when the next report is
//   ready, the block holds that report internally and takes no new record.
//   Reset (rst, synchronous) empties the window, clears the counters, alarm
//   and report valid and restores the register defaults. The ring memory is
//   not cleared; entries are used only after being written.
`default_nettype none

module windowed_mean_slow_alarm_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [wmsa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [wmsa_pkg::CFG_DATA_W-1:0]      cfg_data,
  // turn records in
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // gen_tag[31:0], duration_us[55:32], turn_number[87:56], minutes_value[119:88]
  input  wire logic [wmsa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // reports out
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // report_gen[31:0], fill_count[38:32], mean_us[62:39], alarm_flag[63],
  // alarm_total[95:64], recovery_total[127:96], alarm_mean_us[151:128],
  // turn_out[183:152], minutes_out[215:184]
  output logic [wmsa_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);
  import wmsa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [DUR_W-1:0]    sample_limit;
  logic [PERIOD_W-1:0] publish_period;

  // window and alarm state
  logic [GEN_W-1:0]   current_gen;
  logic [IDX_W-1:0]   head;
  logic [CNT_W-1:0]   fill;
  logic [SUM_W-1:0]   sum;
  logic               slow;
  logic [TOTAL_W-1:0] alarm_total;
  logic [TOTAL_W-1:0] recovery_total;
  logic [DUR_W-1:0]   latched_mean;
  logic [PERIOD_W-1:0] phase;

  // captured record and per-record flags
  logic [DUR_W-1:0]  dur;
  logic [GAME_W-1:0] turn;
  logic [GAME_W-1:0] mins;
  logic [SUM_W-1:0]  limit_x_window;
  logic              publish;
  logic              changed;
  logic              entered;

  // sample ring
  logic [DUR_W-1:0] ring [WINDOW];
  logic [DUR_W-1:0] ring_rd;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [GEN_W-1:0] in_gen;
  logic             in_accept;
  logic             full;
  logic             slow_next;
  logic             report;
  logic             load_report;
  logic [DUR_W-1:0] mean;
  logic [DUR_W-1:0] alarm_mean_val;

  assign in_gen    = s_axis_tdata[31:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign full      = (fill == CNT_W'(WINDOW));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit   <= LIMIT_RESET;
      publish_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SAMPLE_LIMIT:   sample_limit   <= cfg_data;
        REG_PUBLISH_PERIOD: publish_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // ring read: the slot at head, which a full window drops
  assign rd_en   = in_accept;
  assign rd_addr = (in_gen != current_gen) ? '0 : head;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ring_rd <= ring[rd_addr];
    end
    if (state == ST_READ) begin
      ring[head] <= dur;
    end
  end

  // slow decision on the updated window
  assign slow_next = full && (sum > limit_x_window);

  // divider request
  assign div_req.start    = (state == ST_CMP);
  assign div_req.dividend = sum;
  assign div_req.divisor  = fill;

  wmsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign mean           = div_rsp.quotient[DUR_W-1:0];
  assign alarm_mean_val = entered ? mean : latched_mean;
  assign report         = changed || publish || (fill == CNT_W'(1));
  assign load_report    = (state == ST_FIN) && report && (!m_axis_tvalid || m_axis_tready);

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      current_gen    <= '0;
      head           <= '0;
      fill           <= '0;
      sum            <= '0;
      slow           <= 1'b0;
      alarm_total    <= '0;
      recovery_total <= '0;
      latched_mean   <= '0;
      phase          <= '0;
      changed        <= 1'b0;
      entered        <= 1'b0;
      publish        <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      // report valid: set on load, cleared once taken
      if (load_report) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            dur  <= s_axis_tdata[55:32];
            turn <= s_axis_tdata[87:56];
            mins <= s_axis_tdata[119:88];
            if (in_gen != current_gen) begin
              current_gen <= in_gen;
              head        <= '0;
              fill        <= '0;
              sum         <= '0;
              slow        <= 1'b0;
            end
            if (in_gen != '0) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          // drop the oldest sample when full, add the new one
          if (full) begin
            sum <= sum - SUM_W'(ring_rd) + SUM_W'(dur);
          end else begin
            sum  <= sum + SUM_W'(dur);
            fill <= fill + 1'b1;
          end
          head <= (head == IDX_W'(WINDOW - 1)) ? '0 : head + 1'b1;
          limit_x_window <= SUM_W'(sample_limit) * SUM_W'(WINDOW);
          // publish phase; a zero period reports every turn
          if (({1'b0, phase} + 1'b1) >= {1'b0, publish_period}) begin
            phase   <= '0;
            publish <= 1'b1;
          end else begin
            phase   <= phase + 1'b1;
            publish <= 1'b0;
          end
          state <= ST_CMP;
        end
        ST_CMP: begin
          changed <= (slow_next != slow);
          entered <= slow_next && !slow;
          if (slow_next && !slow && alarm_total != '1) begin
            alarm_total <= alarm_total + 1'b1;
          end
          if (!slow_next && slow && recovery_total != '1) begin
            recovery_total <= recovery_total + 1'b1;
          end
          slow  <= slow_next;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!report || load_report) begin
            latched_mean <= alarm_mean_val;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (load_report) begin
      m_axis_tdata <= {mins, turn, alarm_mean_val, recovery_total, alarm_total,
                       slow, mean, REPORT_COUNT_W'(fill), current_gen};
    end
  end

  // window bookkeeping stays consistent
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(WINDOW))
    else $error("fill count above window size");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < IDX_W'(WINDOW))
    else $error("ring head out of range");

  a_slow_full: assert property (@(posedge clk) disable iff (rst)
    slow |-> full)
    else $error("slow state with a partial window");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (sum == '0))
    else $error("nonzero sum in an empty window");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// self-checking bench for the windowed mean slow alarm block: streams turn records,
// predicts every report with its own window and alarm model and compares them
// depends on wmsa_pkg and windowed_mean_slow_alarm_top
`timescale 1ns / 1ps

module tb_top;
  import wmsa_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_RECORDS = 170;

  // turn record as packed on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [GAME_W-1:0] minutes_value;
    logic [GAME_W-1:0] turn_number;
    logic [DUR_W-1:0]  duration_us;
    logic [GEN_W-1:0]  gen_tag;
  } turn_rec_t;

  // report as packed on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [GAME_W-1:0]         minutes_out;
    logic [GAME_W-1:0]         turn_out;
    logic [DUR_W-1:0]          alarm_mean_us;
    logic [TOTAL_W-1:0]        recovery_total;
    logic [TOTAL_W-1:0]        alarm_total;
    logic                      alarm_flag;
    logic [DUR_W-1:0]          mean_us;
    logic [REPORT_COUNT_W-1:0] fill_count;
    logic [GEN_W-1:0]          report_gen;
  } report_t;

  // window model and report store
  class alarm_scoreboard;
    logic [DUR_W-1:0]    limit_us;
    logic [PERIOD_W-1:0] period;
    logic [GEN_W-1:0]    gen_now;
    logic [DUR_W-1:0]    ring [WINDOW];
    int unsigned         head;
    int unsigned         fill;
    logic [SUM_W-1:0]    sum;
    bit                  slow;
    logic [TOTAL_W-1:0]  alarms;
    logic [TOTAL_W-1:0]  recoveries;
    logic [DUR_W-1:0]    alarm_mean;
    logic [PERIOD_W-1:0] phase;
    report_t             pending_reports[$];
    int unsigned         record_count;
    int unsigned         report_count;
    int unsigned         mismatch_count;

    function new();
      limit_us       = LIMIT_RESET;
      period         = PERIOD_RESET;
      gen_now        = '0;
      head           = 0;
      fill           = 0;
      sum            = '0;
      slow           = 1'b0;
      alarms         = '0;
      recoveries     = '0;
      alarm_mean     = '0;
      phase          = '0;
      record_count   = 0;
      report_count   = 0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SAMPLE_LIMIT:   limit_us = value[DUR_W-1:0];
        REG_PUBLISH_PERIOD: period = value[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    // saturating event counter
    function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // advance the window for one accepted record, queue the report it causes
    function void note_record(turn_rec_t rec);
      logic [DUR_W-1:0] mean;
      bit               now_slow;
      bit               crossed;
      bit               publish;
      report_t          rep;
      if (rec.gen_tag != gen_now) begin
        gen_now = rec.gen_tag;
        head    = 0;
        fill    = 0;
        sum     = '0;
        slow    = 1'b0;
      end
      if (rec.gen_tag == '0)
        return;
      record_count++;

      // ring and running sum
      if (fill >= WINDOW)
        sum -= SUM_W'(ring[head]);
      else
        fill++;
      ring[head] = rec.duration_us;
      sum += SUM_W'(rec.duration_us);
      head = (head + 1) % WINDOW;

      // mean and slow decision
      mean     = DUR_W'(sum / SUM_W'(fill));
      now_slow = (fill == WINDOW) && (64'(sum) > 64'(limit_us) * 64'(WINDOW));
      crossed  = now_slow != slow;
      if (crossed) begin
        if (now_slow) begin
          alarms     = bump(alarms);
          alarm_mean = mean;
        end else begin
          recoveries = bump(recoveries);
        end
        slow = now_slow;
      end

      // publish cadence, a zero period behaves as one
      if (32'(phase) + 1 >= 32'(period)) begin
        phase   = '0;
        publish = 1'b1;
      end else begin
        phase   = phase + 1'b1;
        publish = 1'b0;
      end

      if (!crossed && !publish && fill != 1)
        return;
      rep.report_gen     = gen_now;
      rep.fill_count     = REPORT_COUNT_W'(fill);
      rep.mean_us        = mean;
      rep.alarm_flag     = slow;
      rep.alarm_total    = alarms;
      rep.recovery_total = recoveries;
      rep.alarm_mean_us  = alarm_mean;
      rep.turn_out       = rec.turn_number;
      rep.minutes_out    = rec.minutes_value;
      pending_reports.insert(pending_reports.size(), rep);
    endfunction

    function void compare_field(string field, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want_v, got_v);
        mismatch_count++;
      end
    endfunction

    // compare one accepted report with the oldest queued one
    function void check_report(logic [OUT_DATA_W-1:0] bits);
      report_t got;
      report_t want;
      got = bits;
      if (pending_reports.size() == 0) begin
        $error("report for gen 0x%0h arrived with nothing pending", got.report_gen);
        mismatch_count++;
        return;
      end
      want = pending_reports[0];
      pending_reports.delete(0);
      report_count++;
      compare_field("report_gen", want.report_gen, got.report_gen);
      compare_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
      compare_field("mean_us", 32'(want.mean_us), 32'(got.mean_us));
      compare_field("alarm_flag", 32'(want.alarm_flag), 32'(got.alarm_flag));
      compare_field("alarm_total", want.alarm_total, got.alarm_total);
      compare_field("recovery_total", want.recovery_total, got.recovery_total);
      compare_field("alarm_mean_us", 32'(want.alarm_mean_us), 32'(got.alarm_mean_us));
      compare_field("turn_out", want.turn_out, got.turn_out);
      compare_field("minutes_out", want.minutes_out, got.minutes_out);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // gen_tag, duration_us, turn_number, minutes_value
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // report_gen, fill_count, mean_us, alarm_flag, alarm_total, recovery_total,
  // alarm_mean_us, turn_out, minutes_out
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  alarm_scoreboard sb = new();
  bit              steady_flow = 1'b0;
  bit              hold_request = 1'b0;
  int unsigned     settings_count = 0;

  windowed_mean_slow_alarm_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // offer one turn record, with random idle cycles first
  task automatic send_turn(input logic [GEN_W-1:0] gen, input logic [DUR_W-1:0] dur,
                           input logic [GAME_W-1:0] turn, input logic [GAME_W-1:0] mins);
    turn_rec_t rec;
    rec.gen_tag       = gen;
    rec.duration_us   = dur;
    rec.turn_number   = turn;
    rec.minutes_value = mins;
    while (!steady_flow && $urandom_range(99, 0) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rec;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_record(rec);
  endtask

  // stop offering, collect every pending report, then let the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back
  task automatic program_thresholds(input logic [DUR_W-1:0] limit,
                                    input logic [PERIOD_W-1:0] period);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_SAMPLE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    sb.write_reg(REG_SAMPLE_LIMIT, limit);
    cfg_addr <= REG_PUBLISH_PERIOD;
    cfg_data <= CFG_DATA_W'(period);
    @(posedge clk);
    sb.write_reg(REG_PUBLISH_PERIOD, CFG_DATA_W'(period));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  function automatic logic [GEN_W-1:0] fresh_gen();
    logic [GEN_W-1:0] g;
    g = $urandom;
    return (g == '0) ? 32'd1 : g;
  endfunction

  // long same-generation runs whose durations swing above and below the limit,
  // with rare generation changes, generation-zero records and full-range noise
  task automatic run_phase(input logic [DUR_W-1:0] limit, input int unsigned n_records);
    logic [GEN_W-1:0] gen;
    logic [DUR_W-1:0] dur;
    bit               high;
    int unsigned      mode_left;
    int unsigned      recorded;
    int unsigned      roll;
    int unsigned      top;
    gen       = fresh_gen();
    high      = 1'b1;
    mode_left = $urandom_range(130, 110);
    recorded  = 0;
    top       = 2 * limit + 16;
    if (top > 32'hFFFFFF)
      top = 32'hFFFFFF;
    while (recorded < n_records) begin
      roll = $urandom_range(999, 0);
      if (roll < 4) begin
        send_turn('0, DUR_W'($urandom), $urandom, $urandom);
      end else begin
        if (roll < 10)
          gen = fresh_gen();
        if (mode_left == 0) begin
          high      = !high;
          mode_left = $urandom_range(90, 40);
        end
        mode_left--;
        if (roll < 40)
          dur = DUR_W'($urandom);
        else if (high)
          dur = DUR_W'($urandom_range(top, limit));
        else
          dur = DUR_W'($urandom_range(limit, 0));
        send_turn(gen, dur, $urandom, $urandom);
        recorded++;
      end
    end
  endtask

  // report sink with random stalls and one long hold-off on request
  initial begin : report_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(99, 0) >= 28);
      end
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_report(m_axis_tdata);
    end
  end

  // ends the run when no transaction or write happens for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int               ph;
    logic [DUR_W-1:0] lim;
    logic [PERIOD_W-1:0] per;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, generation zero and generation changes
    send_turn('0, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_turn(32'd1, 24'd0, 32'h7FFFFFFF, 32'h80000000);
    send_turn(32'd1, 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_turn(32'd1, 24'h555555, 32'hFFFFFFFF, 32'd0);
    send_turn('0, 24'd0, 32'd0, 32'd0);
    send_turn(32'd1, 24'hAAAAAA, 32'd0, 32'hFFFFFFFF);
    send_turn(32'hFFFFFFFF, 24'hFFFFFF, 32'h12345678, 32'h87654321);
    send_turn(32'hAAAAAAAA, 24'h000001, 32'h55555555, 32'hAAAAAAAA);
    send_turn(32'h55555555, 24'h800000, 32'hAAAAAAAA, 32'h55555555);
    repeat (10) send_turn(32'h55555555, DUR_W'($urandom), $urandom, $urandom);
    wait_idle();

    // period lowered below the running phase
    program_thresholds(LIMIT_RESET, 16'd3);
    repeat (4) send_turn(32'h55555555, DUR_W'($urandom), $urandom, $urandom);
    wait_idle();

    // random phases over several register settings
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          lim = '0;
          per = '0;
        end
        1: begin
          lim = 24'hFFFFFF;
          per = 16'hFFFF;
        end
        2: begin
          lim = DUR_W'($urandom_range(4000000, 1));
          per = 16'd1;
        end
        4: begin
          lim = DUR_W'($urandom_range(8000000, 1000));
          per = PERIOD_W'($urandom_range(300, 17));
        end
        default: begin
          lim = DUR_W'($urandom_range(8000000, 1000));
          per = PERIOD_W'($urandom_range(16, 1));
        end
      endcase
      program_thresholds(lim, per);
      steady_flow = (ph == 3);
      if (ph == 4)
        hold_request = 1'b1;
      run_phase(lim, PHASE_RECORDS);
      wait_idle();
    end

    $display("covered %0d turn records and %0d reports over %0d register settings,",
             sb.record_count, sb.report_count, settings_count);
    $display("with %0d slow alarm entries and %0d recoveries", sb.alarms, sb.recoveries);
    if (sb.mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
